### rtl/sdbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbr_pkg
// Shared types, codes and the CRC16-CCITT byte update for the SD data block
// receiver.
// ----------------------------------------------------------------------------
package sdbr_pkg;

    localparam int BlockLenW  = 13;
    localparam int HuntLimitW = 20;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 20;

    localparam logic [7:0] TOKEN_BYTE = 8'hFE;

    localparam logic [BlockLenW-1:0]  BLOCK_LEN_RESET  = 13'd512;
    localparam logic [HuntLimitW-1:0] HUNT_LIMIT_RESET = 20'd100000;

    localparam logic [CfgIdxW-1:0] CFG_BLOCK_LEN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HUNT_LIMIT = 2'd1;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_OK       = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR  = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic [BlockLenW-1:0]  block_len;
        logic [HuntLimitW-1:0] hunt_limit;
    } sdbr_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       last;
    } sdbr_result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  s;
        logic [7:0]  t;
        logic [15:0] tw;
        s  = b ^ crc[15:8];
        t  = s ^ (s >> 4);
        tw = {8'd0, t};
        return (crc << 8) ^ tw ^ (tw << 5) ^ (tw << 12);
    endfunction

endpackage

### rtl/sdbr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbr channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface sdbr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdbr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;

    modport source (output valid, output kind, output payload, output last, input ready);
    modport sink   (input valid, input kind, input payload, input last, output ready);
endinterface

interface sdbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sdbr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbr_cfg_regs
// Configuration registers: block length and token hunt limit.
// ----------------------------------------------------------------------------
module sdbr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [sdbr_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [sdbr_pkg::CfgDataW-1:0]  wr_data,
    output sdbr_pkg::sdbr_cfg_t            cfg
);
    import sdbr_pkg::*;

    sdbr_cfg_t cfg_reg;
    sdbr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_BLOCK_LEN:  cfg_next.block_len  = wr_data[BlockLenW-1:0];
                CFG_HUNT_LIMIT: cfg_next.hunt_limit = wr_data[HuntLimitW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_len  <= BLOCK_LEN_RESET;
            cfg_reg.hunt_limit <= HUNT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/sdbr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbr_core
// Token hunt with timeout, data pass-through with CRC16 update, and CRC verdict.
// ----------------------------------------------------------------------------
module sdbr_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [7:0]             rx_byte,
    input  sdbr_pkg::sdbr_cfg_t    cfg,
    output logic                   res_valid,
    output sdbr_pkg::sdbr_result_t res
);
    import sdbr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_CRCH = 2'd2;
    localparam logic [1:0] PH_CRCL = 2'd3;

    logic [1:0]            phase_reg,      phase_next;
    logic [HuntLimitW-1:0] hunt_count_reg, hunt_count_next;
    logic [BlockLenW-1:0]  byte_count_reg, byte_count_next;
    logic [15:0]           crc_reg,        crc_next;
    logic [7:0]            crc_high_reg,   crc_high_next;

    logic [HuntLimitW:0]   hunt_inc;
    logic [BlockLenW:0]    byte_inc;

    assign hunt_inc = {1'b0, hunt_count_reg} + {{HuntLimitW{1'b0}}, 1'b1};
    assign byte_inc = {1'b0, byte_count_reg} + {{BlockLenW{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        hunt_count_next = hunt_count_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == TOKEN_BYTE)
                    begin
                        hunt_count_next = '0;
                        byte_count_next = '0;
                        crc_next        = '0;
                        phase_next      = PH_DATA;
                    end
                    else if (hunt_inc >= {1'b0, cfg.hunt_limit})
                    begin
                        hunt_count_next = '0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_TIMEOUT;
                        res.last        = 1'b1;
                    end
                    else
                    begin
                        hunt_count_next = hunt_inc[HuntLimitW-1:0];
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc16_update(crc_reg, rx_byte);
                    if (byte_inc >= {1'b0, cfg.block_len})
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_CRCH;
                    end
                    else
                    begin
                        byte_count_next = byte_inc[BlockLenW-1:0];
                    end
                    res_valid   = 1'b1;
                    res.kind    = KIND_DATA;
                    res.payload = rx_byte;
                end
                PH_CRCH:
                begin
                    crc_high_next = rx_byte;
                    phase_next    = PH_CRCL;
                end
                PH_CRCL:
                begin
                    phase_next      = PH_HUNT;
                    hunt_count_next = '0;
                    res_valid       = 1'b1;
                    res.last        = 1'b1;
                    res.kind        = ({crc_high_reg, rx_byte} == crc_reg) ? KIND_OK
                                                                           : KIND_CRC_ERR;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hunt_count_reg <= '0;
            byte_count_reg <= '0;
            crc_reg        <= '0;
            crc_high_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hunt_count_reg <= hunt_count_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
        end
    end

endmodule

### rtl/sdbr_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbr_out_queue
// Two-entry result queue; decouples input acceptance from output stalls.
// ----------------------------------------------------------------------------
module sdbr_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  sdbr_pkg::sdbr_result_t wr_data,
    output logic                   has_room,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output sdbr_pkg::sdbr_result_t rd_data
);
    import sdbr_pkg::*;

    sdbr_result_t slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg,  count_next;
    logic         rd_fire;

    assign has_room = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_fire;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_fire};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/sd_data_block_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_data_block_receiver_top
// SD SPI-mode data block receiver: start token hunt with timeout, data bytes
// passed through, CRC16-CCITT check of the trailing CRC.
//
//   channel  dir  payload                 transfer when
//   rx       in   rx_byte[7:0]            rx.valid && rx.ready
//   res      out  kind, payload, last     res.valid && res.ready
//   cfg      in   index[1:0], data[19:0]  cfg.valid && cfg.ready (always ready)
//
// One byte per cycle while rx.ready is high; each byte is handled in the cycle
// it is accepted and its result, if any, lands in a two-entry output queue.
// rx.ready drops only while both queue entries wait on res.ready.
// Reset: hunting, counters and CRC cleared, block_len 512, hunt_limit 100000.
// ----------------------------------------------------------------------------
module sd_data_block_receiver_top (
    input  logic       clk,
    input  logic       rst_n,
    sdbr_rx_if.sink    rx,
    sdbr_res_if.source res,
    sdbr_cfg_if.sink   cfg
);
    import sdbr_pkg::*;

    sdbr_cfg_t    cfg_q;
    sdbr_result_t core_res;
    sdbr_result_t q_data;
    logic         core_res_valid;
    logic         q_room;
    logic         in_fire;

    assign rx.ready  = q_room;
    assign in_fire   = rx.valid && q_room;
    assign cfg.ready = 1'b1;

    sdbr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    sdbr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx.rx_byte),
        .cfg       (cfg_q),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    sdbr_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (core_res_valid),
        .wr_data  (core_res),
        .has_room (q_room),
        .rd_valid (res.valid),
        .rd_ready (res.ready),
        .rd_data  (q_data)
    );

    assign res.kind    = q_data.kind;
    assign res.payload = q_data.payload;
    assign res.last    = q_data.last;

endmodule
